>>> rtl/hsb_pkg.sv
// Package for the HSB to ARGB8888 color converter.
// Holds fixed-point widths, sector codes, pipeline stage types and helpers.
// No dependencies; compiled first.
package hsb_pkg;

   // Q8.16 input width and Q0.16 unit value with one guard bit
   localparam int unsigned IN_W   = 24;
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned UNIT_W = FRAC_W + 1;
   localparam logic [UNIT_W-1:0] ONE_Q16 = UNIT_W'(1) << FRAC_W;

   // 6*h fits in 19 bits, the sector is the integer part
   localparam int unsigned HD_W     = FRAC_W + 3;
   localparam logic [2:0]  HUE_MUL6 = 3'd6;

   localparam logic [7:0]  ALPHA_RESET = 8'hFF;
   localparam logic [31:0] WORD_WHITE  = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      SECT_RED_YELLOW    = 3'd0,
      SECT_YELLOW_GREEN  = 3'd1,
      SECT_GREEN_CYAN    = 3'd2,
      SECT_CYAN_BLUE     = 3'd3,
      SECT_BLUE_MAGENTA  = 3'd4,
      SECT_MAGENTA_RED   = 3'd5
   } sector_type;

   typedef logic [UNIT_W-1:0] unit_type;

   // stage 1: clamped inputs and hue split
   typedef struct packed {
      unit_type          sat;
      unit_type          bri;
      sector_type        sector;
      logic [FRAC_W-1:0] frac;
   } stage1_type;

   // stage 2: p and the two multiplicands for q and t
   typedef struct packed {
      unit_type   bri;
      sector_type sector;
      unit_type   p;
      unit_type   q_mul;
      unit_type   t_mul;
   } stage2_type;

   // stage 3: all four channel candidates
   typedef struct packed {
      unit_type   v;
      unit_type   p;
      unit_type   q;
      unit_type   t;
      sector_type sector;
   } stage3_type;

   // Clamp a signed Q8.16 value to 0 through 1.0
   function automatic unit_type clamp_unit(input logic [IN_W-1:0] x);
      unit_type res;
      if (x[IN_W-1]) begin
         res = '0;
      end else if (x[IN_W-2:0] > (IN_W-1)'(ONE_Q16)) begin
         res = ONE_Q16;
      end else begin
         res = x[UNIT_W-1:0];
      end
      return res;
   endfunction

   // Q0.16 product, truncated; operands never exceed 1.0
   function automatic unit_type mul_q16(input unit_type a, input unit_type b);
      logic [2*UNIT_W-1:0] prod;
      prod = a * b;
      return prod[FRAC_W +: UNIT_W];
   endfunction

   // floor(c*255/65536) as c*256 - c, then take the byte
   function automatic logic [7:0] to_byte(input unit_type c);
      logic [UNIT_W+7:0] prod;
      prod = {c, 8'd0} - {8'd0, c};
      return prod[FRAC_W +: 8];
   endfunction

endpackage

>>> rtl/hsb_if.sv
// Handshake channel interfaces for the HSB to ARGB8888 converter.
// Depends on hsb_pkg for field widths.
interface hsb_req_if;
   logic                          valid;
   logic                          ready;
   logic [hsb_pkg::IN_W-1:0]      hue_in;
   logic [hsb_pkg::IN_W-1:0]      saturation_in;
   logic [hsb_pkg::IN_W-1:0]      brightness_in;

   modport source (output valid, hue_in, saturation_in, brightness_in, input ready);
   modport sink   (input valid, hue_in, saturation_in, brightness_in, output ready);
endinterface

interface hsb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] argb_word;
   logic        is_identity;

   modport source (output valid, argb_word, is_identity, input ready);
   modport sink   (input valid, argb_word, is_identity, output ready);
endinterface

>>> rtl/hsb_to_argb8888.sv
// HSB to ARGB8888 converter: four-stage pipeline with a configured alpha byte.
// An accepted request passes the stage 1, 2 and 3 registers and the output register before response valid.
// Throughput: one transaction per cycle; each stage holds under backpressure
// and a bubble in any stage is filled on the next accept.
// Reset (synchronous, active high) empties all stages and sets alpha to 0xFF.
// Depends on hsb_pkg and the channel interfaces in hsb_if.sv.
module hsb_to_argb8888 (
   input  logic              clock,
   input  logic              reset,
   hsb_req_if.sink           req_if,
   hsb_rsp_if.source         rsp_if,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata
);

   logic [7:0]          alpha_ff;
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   hsb_pkg::stage1_type s1_ff, s1_in;
   hsb_pkg::stage2_type s2_ff, s2_in;
   hsb_pkg::stage3_type s3_ff, s3_in;
   logic [31:0]         word_ff, word_in;
   logic                ident_ff;
   logic                rdy_out, rdy3, rdy2, rdy1;
   logic [hsb_pkg::HD_W-1:0] hue_x6;
   hsb_pkg::unit_type   sf, sfc;
   hsb_pkg::unit_type   red, green, blue;

   // Stage ready chain: a stage may load when empty or when it drains
   assign rdy_out      = !out_valid_ff || rsp_if.ready;
   assign rdy3         = !s3_valid_ff  || rdy_out;
   assign rdy2         = !s2_valid_ff  || rdy3;
   assign rdy1         = !s1_valid_ff  || rdy2;
   assign req_if.ready = rdy1;

   // Alpha register
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= hsb_pkg::ALPHA_RESET;
      end else if (csr_we) begin
         alpha_ff <= csr_wdata;
      end
   end

   // Stage 1: clamp, wrap hue, split 6*h into sector and fraction
   always_comb begin
      hue_x6        = hsb_pkg::HD_W'(req_if.hue_in[hsb_pkg::FRAC_W-1:0]) *
                      hsb_pkg::HD_W'(hsb_pkg::HUE_MUL6);
      s1_in.sat     = hsb_pkg::clamp_unit(req_if.saturation_in);
      s1_in.bri     = hsb_pkg::clamp_unit(req_if.brightness_in);
      s1_in.sector  = hsb_pkg::sector_type'(hue_x6[hsb_pkg::HD_W-1:hsb_pkg::FRAC_W]);
      s1_in.frac    = hue_x6[hsb_pkg::FRAC_W-1:0];
   end

   // Stage 2: s*f, s*(1-f) and p in parallel
   always_comb begin
      sf           = hsb_pkg::mul_q16(s1_ff.sat, hsb_pkg::UNIT_W'(s1_ff.frac));
      sfc          = hsb_pkg::mul_q16(s1_ff.sat,
                                      hsb_pkg::ONE_Q16 - hsb_pkg::UNIT_W'(s1_ff.frac));
      s2_in.bri    = s1_ff.bri;
      s2_in.sector = s1_ff.sector;
      s2_in.p      = hsb_pkg::mul_q16(s1_ff.bri, hsb_pkg::ONE_Q16 - s1_ff.sat);
      s2_in.q_mul  = hsb_pkg::ONE_Q16 - sf;
      s2_in.t_mul  = hsb_pkg::ONE_Q16 - sfc;
   end

   // Stage 3: q and t
   always_comb begin
      s3_in.v      = s2_ff.bri;
      s3_in.p      = s2_ff.p;
      s3_in.q      = hsb_pkg::mul_q16(s2_ff.bri, s2_ff.q_mul);
      s3_in.t      = hsb_pkg::mul_q16(s2_ff.bri, s2_ff.t_mul);
      s3_in.sector = s2_ff.sector;
   end

   // Stage 4: route channels by sector, scale to bytes, pack
   always_comb begin
      case (s3_ff.sector)
         hsb_pkg::SECT_RED_YELLOW: begin
            red = s3_ff.v; green = s3_ff.t; blue = s3_ff.p;
         end
         hsb_pkg::SECT_YELLOW_GREEN: begin
            red = s3_ff.q; green = s3_ff.v; blue = s3_ff.p;
         end
         hsb_pkg::SECT_GREEN_CYAN: begin
            red = s3_ff.p; green = s3_ff.v; blue = s3_ff.t;
         end
         hsb_pkg::SECT_CYAN_BLUE: begin
            red = s3_ff.p; green = s3_ff.q; blue = s3_ff.v;
         end
         hsb_pkg::SECT_BLUE_MAGENTA: begin
            red = s3_ff.t; green = s3_ff.p; blue = s3_ff.v;
         end
         default: begin
            red = s3_ff.v; green = s3_ff.p; blue = s3_ff.q;
         end
      endcase
      word_in = {alpha_ff, hsb_pkg::to_byte(red), hsb_pkg::to_byte(green),
                 hsb_pkg::to_byte(blue)};
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy1)    s1_valid_ff  <= req_if.valid;
         if (rdy2)    s2_valid_ff  <= s1_valid_ff;
         if (rdy3)    s3_valid_ff  <= s2_valid_ff;
         if (rdy_out) out_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers: load only when the stage advances
   always_ff @(posedge clock) begin
      if (rdy1 && req_if.valid) s1_ff <= s1_in;
      if (rdy2 && s1_valid_ff)  s2_ff <= s2_in;
      if (rdy3 && s2_valid_ff)  s3_ff <= s3_in;
      if (rdy_out && s3_valid_ff) begin
         word_ff  <= word_in;
         ident_ff <= (word_in == hsb_pkg::WORD_WHITE);
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.argb_word   = word_ff;
   assign rsp_if.is_identity = ident_ff;

   // Sector from 6*h never exceeds five
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_ff.sector <= hsb_pkg::SECT_MAGENTA_RED))
      else $error("sector out of range");

   // Every derived channel stays at or below the brightness
   a_chan_le_v: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_ff.p <= s3_ff.v && s3_ff.q <= s3_ff.v && s3_ff.t <= s3_ff.v))
      else $error("channel exceeds brightness");

   // A stalled middle stage keeps its transaction
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rdy3) |=> (s2_valid_ff && $stable(s2_ff)))
      else $error("stage 2 lost data under stall");

   // White opaque needs alpha 0xFF
   a_ident_alpha: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && ident_ff) |-> (word_ff[31:24] == hsb_pkg::ALPHA_RESET))
      else $error("identity flag with partial alpha");

endmodule

>>> bench/hsb_to_argb8888_tb.sv
`timescale 1ns / 100ps
// Testbench for hsb_to_argb8888: directed table, then random phases under several alpha levels.
// Depends on hsb_pkg and the channel interfaces in hsb_if.sv.
module hsb_to_argb8888_tb;

   localparam logic [16:0] UNIT_ONE    = 17'h10000;
   localparam logic [23:0] LEVEL_ONE   = 24'h010000;
   localparam int          PHASE_ITEMS = 80;
   localparam int          STALL_LIMIT = 500;
   localparam int          DRAIN_WAIT  = 8;

   typedef struct packed {
      logic [31:0] argb_word;
      logic        is_identity;
   } argb_result_type;

   typedef struct packed {
      logic [hsb_pkg::IN_W-1:0] hue;
      logic [hsb_pkg::IN_W-1:0] sat;
      logic [hsb_pkg::IN_W-1:0] bri;
      logic                     typed;
      argb_result_type          result;
   } stim_row_type;

   // Typed rows assume the reset alpha of 0xFF
   localparam int NUM_ROWS = 22;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{24'h000000, LEVEL_ONE,   LEVEL_ONE,   1'b1, '{32'hFFFF0000, 1'b0}}, // pure red
      '{24'h000000, LEVEL_ONE,   24'h000000,  1'b1, '{32'hFF000000, 1'b0}}, // black
      '{24'h123456, LEVEL_ONE,   24'h800000,  1'b1, '{32'hFF000000, 1'b0}}, // negative brightness
      '{24'h000000, 24'h000000,  LEVEL_ONE,   1'b1, '{32'hFFFFFFFF, 1'b1}}, // white
      '{24'h654321, 24'h000000,  24'h7FFFFF,  1'b1, '{32'hFFFFFFFF, 1'b1}}, // brightness clamps
      '{24'h000000, 24'h800000,  LEVEL_ONE,   1'b1, '{32'hFFFFFFFF, 1'b1}}, // negative saturation
      '{24'h000000, 24'h000000,  24'h008000,  1'b1, '{32'hFF7F7F7F, 1'b0}}, // half grey
      '{24'h010000, LEVEL_ONE,   LEVEL_ONE,   1'b1, '{32'hFFFF0000, 1'b0}}, // whole hue
      '{24'h800000, 24'h7FFFFF,  LEVEL_ONE,   1'b1, '{32'hFFFF0000, 1'b0}}, // min hue, max sat
      '{24'hFFC000, LEVEL_ONE,   LEVEL_ONE,   1'b1, '{32'hFF7F00FF, 1'b0}}, // hue of -0.25
      '{24'h00C000, LEVEL_ONE,   LEVEL_ONE,   1'b1, '{32'hFF7F00FF, 1'b0}}, // hue of 0.75
      '{24'h7F0000, 24'h010001,  24'h010001,  1'b1, '{32'hFFFF0000, 1'b0}}, // just over one
      '{24'h7FFFFF, LEVEL_ONE,   LEVEL_ONE,   1'b0, '0},
      '{24'hFFFFFF, LEVEL_ONE,   24'h00C000,  1'b0, '0},
      '{24'h000800, 24'h00C000,  24'h00E000,  1'b0, '0},
      '{24'h003000, LEVEL_ONE,   LEVEL_ONE,   1'b0, '0},
      '{24'h006000, 24'h004000,  LEVEL_ONE,   1'b0, '0},
      '{24'h008800, LEVEL_ONE,   24'h00A000,  1'b0, '0},
      '{24'h00B000, 24'h00FFFF,  24'h00FFFF,  1'b0, '0},
      '{24'h00E000, 24'h000001,  LEVEL_ONE,   1'b0, '0},
      '{24'h002AAB, LEVEL_ONE,   LEVEL_ONE,   1'b0, '0},
      '{24'h005555, 24'h000001,  24'h000001,  1'b0, '0}
   };

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   hsb_req_if req_ch ();
   hsb_rsp_if rsp_ch ();

   hsb_to_argb8888 u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   logic [7:0]      alpha_model;
   bit              no_idle;
   int              error_count = 0;
   int              idle_cycles = 0;
   argb_result_type pending_argb [$];

   // Clamp a signed Q8.16 level to 0 through 1.0
   function automatic logic [16:0] clamp_level(input logic [hsb_pkg::IN_W-1:0] x);
      if (x[hsb_pkg::IN_W-1])
         return '0;
      else if (x > LEVEL_ONE)
         return UNIT_ONE;
      return x[16:0];
   endfunction

   // Q0.16 product, truncated
   function automatic logic [16:0] scale_q16(input logic [16:0] a, input logic [16:0] b);
      logic [33:0] prod;
      prod = a * b;
      return prod[32:16];
   endfunction

   function automatic logic [7:0] channel_byte(input logic [16:0] c);
      logic [24:0] prod;
      prod = c * 25'd255;
      return prod[23:16];
   endfunction

   // Expected packed color for one request transaction
   function automatic argb_result_type predict_argb(input logic [hsb_pkg::IN_W-1:0] hue,
                                                    input logic [hsb_pkg::IN_W-1:0] sat_in,
                                                    input logic [hsb_pkg::IN_W-1:0] bri_in,
                                                    input logic [7:0]               alpha);
      logic [16:0]     s, v, p, q, t, r, g, b, f;
      logic [18:0]     hd;
      argb_result_type res;
      s = clamp_level(sat_in);
      v = clamp_level(bri_in);
      if (v == '0) begin
         r = '0; g = '0; b = '0;
      end else if (s == '0) begin
         r = v; g = v; b = v;
      end else begin
         hd = 19'(hue[15:0]) * 19'd6;
         f  = {1'b0, hd[15:0]};
         p  = scale_q16(v, UNIT_ONE - s);
         q  = scale_q16(v, UNIT_ONE - scale_q16(s, f));
         t  = scale_q16(v, UNIT_ONE - scale_q16(s, UNIT_ONE - f));
         case (hsb_pkg::sector_type'(hd[18:16]))
            hsb_pkg::SECT_RED_YELLOW: begin
               r = v; g = t; b = p;
            end
            hsb_pkg::SECT_YELLOW_GREEN: begin
               r = q; g = v; b = p;
            end
            hsb_pkg::SECT_GREEN_CYAN: begin
               r = p; g = v; b = t;
            end
            hsb_pkg::SECT_CYAN_BLUE: begin
               r = p; g = q; b = v;
            end
            hsb_pkg::SECT_BLUE_MAGENTA: begin
               r = t; g = p; b = v;
            end
            default: begin
               r = v; g = p; b = q;
            end
         endcase
      end
      res.argb_word   = {alpha, channel_byte(r), channel_byte(g), channel_byte(b)};
      res.is_identity = (res.argb_word == hsb_pkg::WORD_WHITE);
      return res;
   endfunction

   // Mostly in-range levels, with zero, one, negatives and overflow mixed in
   function automatic logic [hsb_pkg::IN_W-1:0] pick_level();
      logic [hsb_pkg::IN_W-1:0] lvl;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: lvl = 24'($urandom_range(0, 32'h10000));
         6:                lvl = 24'($urandom());
         7:                lvl = '0;
         8:                lvl = LEVEL_ONE;
         default:          lvl = $urandom_range(0, 1) ? {1'b1, 23'($urandom())} : 24'h010001;
      endcase
      return lvl;
   endfunction

   function automatic logic [hsb_pkg::IN_W-1:0] pick_hue();
      if ($urandom_range(0, 7) == 0)
         return {8'($urandom()), 16'h0000};
      return 24'($urandom());
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Send one request transaction and record what it should produce
   task automatic send_item(input logic [hsb_pkg::IN_W-1:0] hue,
                            input logic [hsb_pkg::IN_W-1:0] sat,
                            input logic [hsb_pkg::IN_W-1:0] bri, input logic typed,
                            input argb_result_type typed_result);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.hue_in        <= hue;
      req_ch.saturation_in <= sat;
      req_ch.brightness_in <= bri;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_argb.push_back(typed ? typed_result : predict_argb(hue, sat, bri, alpha_model));
   endtask

   // Drop valid and wait for every outstanding response
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      while (pending_argb.size() != 0) @(posedge clock);
   endtask

   task automatic write_alpha(input logic [7:0] level);
      csr_we    <= 1'b1;
      csr_wdata <= level;
      @(posedge clock);
      csr_we      <= 1'b0;
      alpha_model  = level;
   endtask

   // Response sink with random stalls
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // Check each response transaction against the oldest expectation
   always @(posedge clock) begin
      argb_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_argb.size() == 0) begin
            $error("response transaction with nothing pending: argb_word %08h",
                   rsp_ch.argb_word);
            error_count++;
         end else begin
            want = pending_argb.pop_front();
            if (rsp_ch.argb_word !== want.argb_word) begin
               $error("argb_word: expected %08h, actual %08h", want.argb_word,
                      rsp_ch.argb_word);
               error_count++;
            end
            if (rsp_ch.is_identity !== want.is_identity) begin
               $error("is_identity: expected %0d, actual %0d", want.is_identity,
                      rsp_ch.is_identity);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("hsb_to_argb8888_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence
   initial begin
      logic [7:0] level;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.hue_in        = '0;
      req_ch.saturation_in = '0;
      req_ch.brightness_in = '0;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      alpha_model          = hsb_pkg::ALPHA_RESET;
      no_idle              = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table under the reset alpha
      for (int i = 0; i < NUM_ROWS; i++) begin
         send_item(DIRECTED_ROWS[i].hue, DIRECTED_ROWS[i].sat, DIRECTED_ROWS[i].bri,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
      end
      drain_pipeline();

      // Random phases, each under its own alpha; one phase runs without idling
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       level = 8'h00;
            1:       level = 8'hFF;
            2:       level = 8'h80;
            default: level = 8'($urandom());
         endcase
         write_alpha(level);
         no_idle = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_item(pick_hue(), pick_level(), pick_level(), 1'b0, '0);
         end
         drain_pipeline();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("hsb_to_argb8888_tb: done, clean");
      else
         $display("hsb_to_argb8888_tb: done, errors");
      $finish;
   end

endmodule
